### sv/dra_pkg.sv
// shared types and constants for the dns reply address extractor
`default_nettype none

package dra_pkg;

  // result kinds
  localparam logic [1:0] KIND_IPV4 = 2'd0;
  localparam logic [1:0] KIND_IPV6 = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // dns constants
  localparam logic [7:0]  MAX_ANSWERS_RESET = 8'd32;
  localparam logic [7:0]  PTR_MARK          = 8'hc0;
  localparam logic [15:0] TYPE_A            = 16'h0001;
  localparam logic [15:0] TYPE_AAAA         = 16'h001c;
  localparam logic [15:0] LEN_A             = 16'd4;
  localparam logic [15:0] LEN_AAAA          = 16'd16;
  localparam logic [15:0] HEADER_LAST_POS   = 16'd11;
  localparam logic [15:0] QTAIL_BYTES       = 16'd4;
  localparam logic [15:0] FIXED_BYTES       = 16'd10;
  localparam logic [7:0]  COUNT_MAX         = 8'd255;

  // one payload byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       name_known;
  } in_item_t;

  // one result
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  found_count;
  } out_item_t;

endpackage

`default_nettype wire

### sv/dns_reply_address_extractor.sv
// dns reply parser that pulls a and aaaa addresses out of a byte stream
//
// Takes one DNS payload byte per cycle and emits one result transaction per
// found IPv4/IPv6 address plus an end marker carrying the address count when
// the byte flagged last_byte has been parsed. Throughput is one byte per cycle
// while the output queue has room; a byte is held in the input register and
// its results are written to the output queue (OUT_DEPTH entries) when it is
// parsed. A byte is parsed only when the queue has room for two results, so
// in_ready drops while the consumer holds off and the queue is nearly full.
// The user must write max_answers through cfg only while idle; the block does
// not enforce this.
`default_nettype none

module dns_reply_address_extractor
  import dra_pkg::*;
#(
  parameter int OUT_DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [7:0] cfg_data
);

  localparam int PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(OUT_DEPTH - 2);
  localparam logic [PW-1:0] LAST_IDX   = PW'(OUT_DEPTH - 1);

  typedef enum logic [2:0] {
    PH_HEADER, PH_IGNORE, PH_QNAME, PH_QTAIL,
    PH_ANAME, PH_APTR, PH_AFIXED, PH_RDATA
  } phase_t;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  // configuration register
  logic [7:0] max_answers;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_answers <= MAX_ANSWERS_RESET;
    end else if (cfg_valid) begin
      max_answers <= cfg_data;
    end
  end

  // input register
  logic     s1_valid;
  in_item_t s1_item;
  logic     parse_en;

  // output queue
  out_item_t       fifo [OUT_DEPTH];
  logic [PW-1:0]   rd_ptr;
  logic [PW-1:0]   wr_ptr;
  logic [CW-1:0]   count;
  logic            pop;
  logic [CW-1:0]   count_after_pop;

  assign out_valid       = (count != '0);
  assign out_data        = fifo[rd_ptr];
  assign pop             = out_valid && out_ready;
  assign count_after_pop = count - CW'(pop);
  assign parse_en        = s1_valid && (count_after_pop <= ROOM_LIMIT);
  assign in_ready        = !s1_valid || parse_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

  // parser state
  phase_t      phase, phase_next;
  logic [15:0] pos, pos_next;
  logic [15:0] flags, flags_next;
  logic [15:0] qleft, qleft_next;
  logic [7:0]  aleft, aleft_next;
  logic [15:0] rtype, rtype_next;
  logic [15:0] rlen, rlen_next;
  logic [63:0] ash0, ash0_next;
  logic [63:0] ash1, ash1_next;
  logic [7:0]  total, total_next;
  logic        enabled, enabled_next;

  out_item_t   res [2];
  logic [1:0]  n_res;

  logic [7:0]  b;
  logic [15:0] pos_inc;
  logic [7:0]  aleft_dec;
  phase_t      phase_after_answer;
  logic [15:0] qleft_dec;
  logic        is_v4;
  logic        is_v6;

  // per-byte parse step
  always_comb begin
    b                  = s1_item.data_byte;
    pos_inc            = pos + 16'd1;
    aleft_dec          = (aleft != 8'd0) ? aleft - 8'd1 : 8'd0;
    phase_after_answer = (aleft_dec != 8'd0) ? PH_ANAME : PH_IGNORE;
    qleft_dec          = (qleft != 16'd0) ? qleft - 16'd1 : 16'd0;
    is_v4              = (rtype == TYPE_A) && (rlen == LEN_A);
    is_v6              = (rtype == TYPE_AAAA) && (rlen == LEN_AAAA);

    phase_next   = phase;
    pos_next     = pos;
    flags_next   = flags;
    qleft_next   = qleft;
    aleft_next   = aleft;
    rtype_next   = rtype;
    rlen_next    = rlen;
    ash0_next    = ash0;
    ash1_next    = ash1;
    total_next   = total;
    enabled_next = enabled;
    res[0]       = '0;
    res[1]       = '0;
    n_res        = 2'd0;

    case (phase)
      PH_HEADER: begin
        if (pos == 16'd0) begin
          enabled_next = s1_item.name_known;
        end
        case (pos)
          16'd2:   flags_next = {b, 8'h00};
          16'd3:   flags_next = {flags[15:8], b};
          16'd4:   qleft_next = {b, 8'h00};
          16'd5:   qleft_next = {qleft[15:8], b};
          16'd6:   rlen_next  = {b, 8'h00};
          16'd7:   rlen_next  = {rlen[15:8], b};
          default: ;
        endcase
        if (pos >= HEADER_LAST_POS) begin
          pos_next = 16'd0;
          if (enabled_next && flags_next[15] && qleft_next != 16'd0 &&
              rlen_next != 16'd0) begin
            aleft_next = (rlen_next > {8'h00, max_answers}) ? max_answers
                                                             : rlen_next[7:0];
            phase_next = PH_QNAME;
          end else begin
            phase_next = PH_IGNORE;
          end
          rlen_next = 16'd0;
        end else begin
          pos_next = pos_inc;
        end
      end
      PH_IGNORE: ;
      PH_QNAME: begin
        if (b == 8'h00) begin
          phase_next = PH_QTAIL;
          pos_next   = 16'd0;
        end
      end
      PH_QTAIL: begin
        if (pos_inc >= QTAIL_BYTES) begin
          pos_next   = 16'd0;
          qleft_next = qleft_dec;
          if (qleft_dec != 16'd0) begin
            phase_next = PH_QNAME;
          end else begin
            phase_next = (aleft != 8'd0) ? PH_ANAME : PH_IGNORE;
          end
        end else begin
          pos_next = pos_inc;
        end
      end
      PH_ANAME: begin
        if (b == 8'h00) begin
          phase_next = PH_AFIXED;
          pos_next   = 16'd0;
        end else if (b == PTR_MARK) begin
          phase_next = PH_APTR;
        end
      end
      PH_APTR: begin
        phase_next = PH_AFIXED;
        pos_next   = 16'd0;
      end
      PH_AFIXED: begin
        case (pos)
          16'd0:   rtype_next = {b, 8'h00};
          16'd1:   rtype_next = {rtype[15:8], b};
          16'd8:   rlen_next  = {b, 8'h00};
          16'd9:   rlen_next  = {rlen[15:8], b};
          default: ;
        endcase
        if (pos_inc >= FIXED_BYTES) begin
          pos_next  = 16'd0;
          ash0_next = 64'd0;
          ash1_next = 64'd0;
          if (rlen_next == 16'd0) begin
            aleft_next = aleft_dec;
            phase_next = phase_after_answer;
          end else begin
            phase_next = PH_RDATA;
          end
        end else begin
          pos_next = pos_inc;
        end
      end
      PH_RDATA: begin
        ash0_next = {ash0[55:0], ash1[63:56]};
        ash1_next = {ash1[55:0], b};
        if (pos_inc >= rlen) begin
          if (is_v4 || is_v6) begin
            total_next = (total < COUNT_MAX) ? total + 8'd1 : total;
            res[0].found_count = total_next;
            if (is_v4) begin
              res[0].kind     = KIND_IPV4;
              res[0].addr_low = {32'd0, ash1_next[31:0]};
            end else begin
              res[0].kind      = KIND_IPV6;
              res[0].addr_high = ash0_next;
              res[0].addr_low  = ash1_next;
            end
            n_res = 2'd1;
          end
          aleft_next = aleft_dec;
          phase_next = phase_after_answer;
          pos_next   = 16'd0;
        end else begin
          pos_next = pos_inc;
        end
      end
      default: phase_next = PH_IGNORE;
    endcase

    // end marker and packet clear
    if (s1_item.last_byte) begin
      res[n_res[0]].kind        = KIND_END;
      res[n_res[0]].addr_high   = 64'd0;
      res[n_res[0]].addr_low    = 64'd0;
      res[n_res[0]].found_count = total_next;
      n_res        = n_res + 2'd1;
      phase_next   = PH_HEADER;
      pos_next     = 16'd0;
      flags_next   = 16'd0;
      qleft_next   = 16'd0;
      aleft_next   = 8'd0;
      rtype_next   = 16'd0;
      rlen_next    = 16'd0;
      ash0_next    = 64'd0;
      ash1_next    = 64'd0;
      total_next   = 8'd0;
      enabled_next = 1'b0;
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEADER;
      pos     <= 16'd0;
      flags   <= 16'd0;
      qleft   <= 16'd0;
      aleft   <= 8'd0;
      rtype   <= 16'd0;
      rlen    <= 16'd0;
      ash0    <= 64'd0;
      ash1    <= 64'd0;
      total   <= 8'd0;
      enabled <= 1'b0;
    end else if (parse_en) begin
      phase   <= phase_next;
      pos     <= pos_next;
      flags   <= flags_next;
      qleft   <= qleft_next;
      aleft   <= aleft_next;
      rtype   <= rtype_next;
      rlen    <= rlen_next;
      ash0    <= ash0_next;
      ash1    <= ash1_next;
      total   <= total_next;
      enabled <= enabled_next;
    end
  end

  // result queue pointers and storage
  logic [1:0]    n_push;
  logic [PW-1:0] wr_ptr2;

  assign n_push  = parse_en ? n_res : 2'd0;
  assign wr_ptr2 = ptr_inc(wr_ptr);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case (n_push)
        2'd1:    wr_ptr <= wr_ptr2;
        2'd2:    wr_ptr <= ptr_inc(wr_ptr2);
        default: ;
      endcase
      count <= count_after_pop + CW'(n_push);
    end
    if (n_push != 2'd0) begin
      fifo[wr_ptr] <= res[0];
    end
    if (n_push == 2'd2) begin
      fifo[wr_ptr2] <= res[1];
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(OUT_DEPTH))
    else $error("result queue overflow");

  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    parse_en && s1_item.last_byte |=> out_valid && phase == PH_HEADER && total == 8'd0)
    else $error("last byte did not queue an end marker and clear the packet");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !parse_en |=> s1_valid && $stable(s1_item))
    else $error("stalled input item lost or changed");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> !pop)
    else $error("pop from empty result queue");

endmodule

`default_nettype wire
